FILE: hw/rtl/rhot_pkg.sv
// Shared types and constants of the raised-hand order tracker.
`default_nettype none

package rhot_pkg;

	localparam int MAX_TRACKED_DEF = 16;
	localparam int ID_W = 8;
	localparam int COORD_W = 16;
	localparam int XYZ_W = 3 * COORD_W;
	localparam int HEAD_MARGIN_W = 10;
	localparam int ELBOW_MARGIN_W = 10;
	localparam int RADIUS_W = 12;
	localparam int R2_W = 2 * RADIUS_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;
	localparam int COUNT_OUT_W = 5;

	localparam logic [HEAD_MARGIN_W-1:0] HEAD_MARGIN_RST = 10'd30;
	localparam logic [ELBOW_MARGIN_W-1:0] ELBOW_MARGIN_RST = 10'd20;
	localparam logic [RADIUS_W-1:0] REACH_RADIUS_RST = 12'd120;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_MARGIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ELBOW_MARGIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REACH_RADIUS = 2'd2;

	localparam logic OP_SKELETON = 1'b0;
	localparam logic OP_EOF = 1'b1;

	typedef struct packed {
		logic valid;
		logic seen;
		logic [ID_W-1:0] id;
	} cell_t;

	typedef struct packed {
		logic mark;
		logic insert;
		logic remove;
		logic clear_seen;
		logic [ID_W-1:0] uid;
	} cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rhot_hand.sv
// Raised-hand test for one hand: height checks and squared horizontal distance.
`default_nettype none

module rhot_hand
	import rhot_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [XYZ_W-1:0]          hand,
	input  wire logic [COORD_W-1:0]        elbow_z,
	input  wire logic [XYZ_W-1:0]          head,
	input  wire logic [HEAD_MARGIN_W-1:0]  head_margin,
	input  wire logic [ELBOW_MARGIN_W-1:0] elbow_margin,
	input  wire logic [R2_W-1:0]           r2,
	output logic                           up
);

	localparam int Z_W = COORD_W + 2;
	localparam int D_W = COORD_W + 1;
	localparam int SQ_W = 2 * COORD_W;

	logic signed [Z_W-1:0] hz;
	logic signed [Z_W-1:0] ez_lim;
	logic signed [Z_W-1:0] el_lim;
	logic signed [D_W-1:0] dx;
	logic signed [D_W-1:0] dy;
	logic signed [2*D_W-1:0] px;
	logic signed [2*D_W-1:0] py;
	logic [SQ_W:0] d2;

	logic z_ok_q;
	logic [SQ_W-1:0] sqx_q;
	logic [SQ_W-1:0] sqy_q;

	always_comb begin
		hz = signed'({{2{hand[3*COORD_W-1]}}, hand[3*COORD_W-1:2*COORD_W]});
		ez_lim = signed'({{2{head[3*COORD_W-1]}}, head[3*COORD_W-1:2*COORD_W]})
			+ signed'({{(Z_W-HEAD_MARGIN_W){1'b0}}, head_margin});
		el_lim = signed'({{2{elbow_z[COORD_W-1]}}, elbow_z})
			+ signed'({{(Z_W-ELBOW_MARGIN_W){1'b0}}, elbow_margin});
		dx = signed'({hand[COORD_W-1], hand[COORD_W-1:0]})
			- signed'({head[COORD_W-1], head[COORD_W-1:0]});
		dy = signed'({hand[2*COORD_W-1], hand[2*COORD_W-1:COORD_W]})
			- signed'({head[2*COORD_W-1], head[2*COORD_W-1:COORD_W]});
		px = dx * dx;
		py = dy * dy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_ok_q <= (hz > ez_lim) && (hz > el_lim);
			sqx_q <= px[SQ_W-1:0];
			sqy_q <= py[SQ_W-1:0];
		end
	end

	assign d2 = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign up = z_ok_q && (d2 > {{(SQ_W+1-R2_W){1'b0}}, r2});

endmodule

`default_nettype wire

FILE: hw/rtl/rhot_cell.sv
// One entry of the ordered raised-hand list, shifting toward the oldest end on removal.
`default_nettype none

module rhot_cell
	import rhot_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire logic prev_valid,
	input  wire logic hit_in,
	input  wire cell_t nxt,
	output logic      hit_out,
	output cell_t     st
);

	logic valid_q;
	logic seen_q;
	logic [ID_W-1:0] id_q;
	logic match;
	logic shift;
	logic take;

	assign match = valid_q && (id_q == cmd.uid);
	assign hit_out = hit_in || match;
	assign shift = cmd.remove && hit_out;
	assign take = cmd.insert && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			seen_q <= 1'b0;
		end else if (cmd.clear_seen) begin
			seen_q <= 1'b0;
		end else if (shift) begin
			valid_q <= nxt.valid;
			seen_q <= nxt.seen;
		end else if (take) begin
			valid_q <= 1'b1;
			seen_q <= 1'b1;
		end else if (cmd.mark && match) begin
			seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd.clear_seen && shift) begin
			id_q <= nxt.id;
		end else if (!cmd.clear_seen && take) begin
			id_q <= cmd.uid;
		end
	end

	assign st = '{valid: valid_q, seen: seen_q, id: id_q};

endmodule

`default_nettype wire

FILE: hw/rtl/raised_hand_order_tracker.sv
// Top level of the raised-hand order tracker: control, hand tests and the list of cells.
//
// The input channel carries one request per item: a user skeleton (op 0) or an
// end-of-frame marker (op 1). Each request passes through capture, hand
// arithmetic (squared horizontal distances and height checks) and the list
// update, which reaches every cell of the list at once. A new request is taken
// only when the previous one has finished. Skeleton requests give no result. An
// end-of-frame request gives one result on the output channel, registered when
// its list update is applied and held in an output register; while the receiver
// stalls that register, a following end-of-frame request waits in its update
// step and the input stalls. Skeleton requests still pass while a result waits.
// Configuration writes are taken at any edge with the write enable high. Reset
// empties the list, clears the seen marks and the drop flag, and loads the
// default margins and radius.
`default_nettype none

module raised_hand_order_tracker
	import rhot_pkg::*;
#(
	parameter int MAX_TRACKED = MAX_TRACKED_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  op,
	input  wire logic [ID_W-1:0]       user_id,
	input  wire logic [XYZ_W-1:0]      left_hand_xyz,
	input  wire logic [COORD_W-1:0]    left_elbow_z,
	input  wire logic [XYZ_W-1:0]      head_xyz,
	input  wire logic [COORD_W-1:0]    right_elbow_z,
	input  wire logic [XYZ_W-1:0]      right_hand_xyz,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       found,
	output logic [ID_W-1:0]            selected_id,
	output logic [COUNT_OUT_W-1:0]     list_count,
	output logic                       dropped
);

	localparam int CW = $clog2(MAX_TRACKED + 1);
	localparam int CNT_W = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CALC  = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	state_t state_q;

	logic [HEAD_MARGIN_W-1:0] head_margin_q;
	logic [ELBOW_MARGIN_W-1:0] elbow_margin_q;
	logic [RADIUS_W-1:0] reach_radius_q;
	logic [R2_W-1:0] r2_q;

	logic op_q;
	logic [ID_W-1:0] uid_q;
	logic [XYZ_W-1:0] lhand_q;
	logic [COORD_W-1:0] lelbow_q;
	logic [XYZ_W-1:0] head_q;
	logic [COORD_W-1:0] relbow_q;
	logic [XYZ_W-1:0] rhand_q;

	logic [CNT_W-1:0] cnt_q;
	logic drop_flag_q;
	logic out_valid_q;
	logic found_q;
	logic [ID_W-1:0] selected_id_q;
	logic [COUNT_OUT_W-1:0] list_count_q;
	logic dropped_q;

	logic up_l;
	logic up_r;
	logic raised;
	logic is_eof;
	logic apply_go;
	logic any_match;
	logic full;
	cmd_t cmd;

	cell_t cell_st [MAX_TRACKED+1];
	logic [MAX_TRACKED:0] hit_c;
	logic [MAX_TRACKED:0] valid_c;

	assign in_stall = (state_q != ST_IDLE);
	assign is_eof = (op_q == OP_EOF);
	assign apply_go = (state_q == ST_APPLY) && (!is_eof || !out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_margin_q <= HEAD_MARGIN_RST;
			elbow_margin_q <= ELBOW_MARGIN_RST;
			reach_radius_q <= REACH_RADIUS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEAD_MARGIN: head_margin_q <= cfg_data[HEAD_MARGIN_W-1:0];
				CFG_ELBOW_MARGIN: elbow_margin_q <= cfg_data[ELBOW_MARGIN_W-1:0];
				CFG_REACH_RADIUS: reach_radius_q <= cfg_data[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q <= op;
			uid_q <= user_id;
			lhand_q <= left_hand_xyz;
			lelbow_q <= left_elbow_z;
			head_q <= head_xyz;
			relbow_q <= right_elbow_z;
			rhand_q <= right_hand_xyz;
		end
		if (state_q == ST_CALC) begin
			r2_q <= reach_radius_q * reach_radius_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_CALC;
				ST_CALC: state_q <= ST_APPLY;
				ST_APPLY: if (apply_go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	rhot_hand u_hand_l (
		.clk          (clk),
		.en           (state_q == ST_CALC),
		.hand         (lhand_q),
		.elbow_z      (lelbow_q),
		.head         (head_q),
		.head_margin  (head_margin_q),
		.elbow_margin (elbow_margin_q),
		.r2           (r2_q),
		.up           (up_l)
	);

	rhot_hand u_hand_r (
		.clk          (clk),
		.en           (state_q == ST_CALC),
		.hand         (rhand_q),
		.elbow_z      (relbow_q),
		.head         (head_q),
		.head_margin  (head_margin_q),
		.elbow_margin (elbow_margin_q),
		.r2           (r2_q),
		.up           (up_r)
	);

	assign raised = up_l || up_r;
	assign any_match = hit_c[MAX_TRACKED];
	assign full = (cnt_q == CNT_W'(MAX_TRACKED));

	always_comb begin
		cmd.uid = uid_q;
		cmd.clear_seen = apply_go && is_eof;
		cmd.mark = apply_go && !is_eof && raised && any_match;
		cmd.insert = apply_go && !is_eof && raised && !any_match && !full;
		cmd.remove = apply_go && !is_eof && !raised && any_match;
	end

	assign hit_c[0] = 1'b0;
	assign valid_c[0] = 1'b1;
	assign cell_st[MAX_TRACKED] = '0;

	for (genvar i = 0; i < MAX_TRACKED; i++) begin : g_cell
		rhot_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_valid (valid_c[i]),
			.hit_in     (hit_c[i]),
			.nxt        (cell_st[i+1]),
			.hit_out    (hit_c[i+1]),
			.st         (cell_st[i])
		);
		assign valid_c[i+1] = cell_st[i].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			drop_flag_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.insert) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.remove) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.clear_seen) begin
				drop_flag_q <= 1'b0;
			end else if (apply_go && raised && !any_match && full) begin
				drop_flag_q <= 1'b1;
			end
			if (cmd.clear_seen) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_seen) begin
			found_q <= cell_st[0].valid && cell_st[0].seen;
			selected_id_q <= (cell_st[0].valid && cell_st[0].seen) ? cell_st[0].id : '0;
			list_count_q <= cnt_q[COUNT_OUT_W-1:0];
			dropped_q <= drop_flag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign selected_id = selected_id_q;
	assign list_count = list_count_q;
	assign dropped = dropped_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rhot_checker.sv
// Port-level checks of the raised-hand order tracker and their binding.
`default_nettype none

module rhot_checker
	import rhot_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_stall,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic                   found,
	input wire logic [ID_W-1:0]        selected_id,
	input wire logic [COUNT_OUT_W-1:0] list_count
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(selected_id)
			&& $stable(list_count))
		else $error("stalled result changed");

	// A result without a seen user names no user.
	a_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> selected_id == '0)
		else $error("selected_id set without found");

	// A found user means the list is not empty.
	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> list_count != '0)
		else $error("found with an empty list");

	// Every accepted request keeps the input busy while it is processed.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall)
		else $error("request accepted before the previous one finished");

endmodule

bind raised_hand_order_tracker rhot_checker u_rhot_checker (.*);

`default_nettype wire
